>>> hdl/ple_pkg.sv
// Package for the positional list engine: action and status codes,
// transaction structs and the state machine type. No dependencies.
`default_nettype none
package ple_pkg;

  typedef enum logic [3:0] {
    ACT_INS_FRONT = 4'd0,
    ACT_INS_BACK  = 4'd1,
    ACT_INS_AT    = 4'd2,
    ACT_DEL_FRONT = 4'd3,
    ACT_DEL_BACK  = 4'd4,
    ACT_DEL_AT    = 4'd5,
    ACT_SEARCH    = 4'd6,
    ACT_UPDATE    = 4'd7,
    ACT_SORT      = 4'd8,
    ACT_DUMP_FWD  = 4'd9,
    ACT_DUMP_BACK = 4'd10
  } action_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic [3:0]         action;
    logic signed [31:0] value;
    logic [5:0]         position;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] value_out;
    logic [5:0]         found_position;
    logic               last;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,      // read issued for index idx (idx-1 for an insert shift)
    S_WAIT,    // read data arrives
    S_SORT_RD,
    S_SORT_WT,
    S_SORT_CMP,
    S_OUT      // result held until taken
  } state_e;

endpackage
`default_nettype wire

>>> hdl/ple_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module ple_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

>>> hdl/positional_list_engine.sv
// Positional list engine top level: a sequencer around one list memory.
// Depends on ple_pkg and ple_ram.
`default_nettype none
// Usage:
// The request channel (req_valid_i/req_ready_o/req_i) takes one action per
// transaction. The response channel (rsp_valid_o/rsp_ready_i/rsp_o) returns
// one transaction per action, or one per element for a dump, with last set
// on the final one. Action codes 11 to 15 are dropped with no response.
// The list lives in one single-port RAM with registered read data, so
// every element move is a read, then a write. An insert or delete shifts
// the tail one element at a time. A search walks the list element by
// element; a dump reads the next element only after the last one is
// taken by the receiver. Update is a single write with no read.
// Sort is an insertion sort over the RAM.
// Only one action is worked on at a time; req_ready_o is high in idle.
// When the receiver stalls, the result is held in the output register and
// the walk pauses until it is taken. Reset empties the list at once; the
// memory contents are not cleared, since entries past the count are never
// read.
module positional_list_engine #(
  parameter int Capacity = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         req_valid_i,
  output logic              req_ready_o,
  input  wire ple_pkg::req_t req_i,
  output logic              rsp_valid_o,
  input  wire logic         rsp_ready_i,
  output ple_pkg::rsp_t     rsp_o
);
  import ple_pkg::*;

  localparam int AW = $clog2(Capacity);
  localparam int CW = $clog2(Capacity + 1);

  state_e state_q, state_d;
  req_t   req_q, req_d;
  logic [CW-1:0] cnt_q, cnt_d;
  // idx: element being read; tgt: element index of the action; key holds the
  // insert value and the sort key.
  logic [CW-1:0] idx_q, idx_d, tgt_q, tgt_d, i_q, i_d;
  logic [31:0] key_q, key_d;
  logic  cont_q, cont_d;  // after response, continue a dump
  rsp_t  rsp_q, rsp_d;

  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   wdata, rdata;

  ple_ram #(.Width(32), .Depth(Capacity)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      cont_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cont_q  <= cont_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    idx_q <= idx_d;
    tgt_q <= tgt_d;
    i_q   <= i_d;
    key_q <= key_d;
    rsp_q <= rsp_d;
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_OUT);
  assign rsp_o       = rsp_q;

  function automatic rsp_t mk(input status_e s, input logic [31:0] v,
                              input logic [5:0] f, input logic l);
    rsp_t r;
    r.status = s; r.value_out = v; r.found_position = f; r.last = l;
    return r;
  endfunction

  logic          is_ins, is_del, dump_fwd;
  assign is_ins   = (req_q.action == ACT_INS_FRONT) || (req_q.action == ACT_INS_BACK) ||
                    (req_q.action == ACT_INS_AT);
  assign is_del   = (req_q.action == ACT_DEL_FRONT) || (req_q.action == ACT_DEL_BACK) ||
                    (req_q.action == ACT_DEL_AT);
  assign dump_fwd = (req_q.action == ACT_DUMP_FWD);

  // Insert shifts from the back: read idx-1, write idx. Delete shifts forward.
  always_comb begin
    logic [CW-1:0] p;
    logic [6:0]    pw;
    p  = '0;
    pw = '0;
    state_d = state_q;
    req_d = req_q; cnt_d = cnt_q; idx_d = idx_q; tgt_d = tgt_q; i_d = i_q;
    key_d = key_q; cont_d = cont_q; rsp_d = rsp_q;
    we = 1'b0; addr = idx_q[AW-1:0]; wdata = key_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_d = req_i;
          pw = {1'b0, req_i.position};
          p  = CW'(req_i.position);
          state_d = S_OUT;
          cont_d  = 1'b0;
          case (action_e'(req_i.action))
            ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
              if (cnt_q >= CW'(Capacity)) begin
                rsp_d = mk(ST_FULL, '0, '0, 1'b1);
              end else begin
                if (req_i.action == ACT_INS_FRONT) tgt_d = '0;
                else if (req_i.action == ACT_INS_BACK) tgt_d = cnt_q;
                else tgt_d = p - 1'b1;
                if (req_i.action == ACT_INS_AT &&
                    (pw == 7'd0 || pw > 7'(cnt_q == '0 ? CW'(1) : cnt_q))) begin
                  rsp_d = mk(ST_BADPOS, '0, '0, 1'b1);
                end else begin
                  idx_d = cnt_q;
                  key_d = req_i.value;
                  state_d = S_RD;
                end
              end
            end
            ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_AT, ACT_UPDATE: begin
              if (cnt_q == '0) begin
                rsp_d = mk(ST_EMPTY, '0, '0, 1'b1);
              end else if ((req_i.action == ACT_DEL_AT || req_i.action == ACT_UPDATE) &&
                           (pw == 7'd0 || pw > 7'(cnt_q))) begin
                rsp_d = mk(ST_BADPOS, '0, '0, 1'b1);
              end else begin
                if (req_i.action == ACT_DEL_FRONT) tgt_d = '0;
                else if (req_i.action == ACT_DEL_BACK) tgt_d = cnt_q - 1'b1;
                else tgt_d = p - 1'b1;
                idx_d = tgt_d;
                state_d = S_RD;
              end
            end
            ACT_SEARCH: begin
              if (cnt_q == '0) rsp_d = mk(ST_NOTFOUND, '0, '0, 1'b1);
              else begin idx_d = '0; state_d = S_RD; end
            end
            ACT_SORT: begin
              if (cnt_q == '0) rsp_d = mk(ST_EMPTY, '0, '0, 1'b1);
              else if (cnt_q == CW'(1)) rsp_d = mk(ST_OK, '0, '0, 1'b1);
              else begin i_d = CW'(1); idx_d = CW'(1); state_d = S_RD; end
            end
            ACT_DUMP_FWD, ACT_DUMP_BACK: begin
              if (cnt_q == '0) rsp_d = mk(ST_EMPTY, '0, '0, 1'b1);
              else begin
                i_d = '0;
                idx_d = (req_i.action == ACT_DUMP_FWD) ? '0 : cnt_q - 1'b1;
                state_d = S_RD;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        // Insert: once idx reaches tgt, write the new value there.
        if (is_ins && idx_q == tgt_q) begin
          we = 1'b1; wdata = key_q;
          cnt_d = cnt_q + 1'b1;
          rsp_d = mk(ST_OK, '0, '0, 1'b1);
          state_d = S_OUT;
        end else if (req_q.action == ACT_UPDATE) begin
          we = 1'b1; wdata = req_q.value;
          rsp_d = mk(ST_OK, '0, '0, 1'b1);
          state_d = S_OUT;
        end else begin
          addr = is_ins ? AW'(idx_q - 1'b1) : idx_q[AW-1:0];
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        case (action_e'(req_q.action))
          ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
            we = 1'b1; wdata = rdata;
            idx_d = idx_q - 1'b1;
            state_d = S_RD;
          end
          ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_AT: begin
            if (idx_q == tgt_q) rsp_d = mk(ST_OK, rdata, '0, 1'b1);
            else begin
              we = 1'b1; wdata = rdata; addr = AW'(idx_q - 1'b1);
            end
            if (idx_q + 1'b1 >= cnt_q) begin
              cnt_d = cnt_q - 1'b1;
              state_d = S_OUT;
            end else begin
              idx_d = idx_q + 1'b1;
              state_d = S_RD;
            end
          end
          ACT_SEARCH: begin
            if (rdata == req_q.value) begin
              rsp_d = mk(ST_OK, '0, 6'(idx_q + 1'b1), 1'b1);
              state_d = S_OUT;
            end else if (idx_q + 1'b1 >= cnt_q) begin
              rsp_d = mk(ST_NOTFOUND, '0, '0, 1'b1);
              state_d = S_OUT;
            end else begin
              idx_d = idx_q + 1'b1; state_d = S_RD;
            end
          end
          ACT_SORT: begin
            // Key read at i; then walk j = idx down.
            key_d = rdata;
            state_d = S_SORT_RD;
          end
          default: begin
            rsp_d = mk(ST_OK, rdata, '0, (i_q + 1'b1 == cnt_q));
            cont_d = (i_q + 1'b1 != cnt_q);
            i_d = i_q + 1'b1;
            idx_d = dump_fwd ? idx_q + 1'b1 : idx_q - 1'b1;
            state_d = S_OUT;
          end
        endcase
      end
      S_SORT_RD: begin
        if (idx_q == '0) begin
          we = 1'b1; wdata = key_q;
          state_d = S_SORT_CMP;
        end else begin
          addr = AW'(idx_q - 1'b1);
          state_d = S_SORT_WT;
        end
      end
      S_SORT_WT: begin
        if ($signed(rdata) > $signed(key_q)) begin
          we = 1'b1; wdata = rdata;
          idx_d = idx_q - 1'b1;
          state_d = S_SORT_RD;
        end else begin
          we = 1'b1; wdata = key_q;
          state_d = S_SORT_CMP;
        end
      end
      S_SORT_CMP: begin
        // Advance to the next key, or finish when every key is placed.
        if (i_q + 1'b1 >= cnt_q) begin
          rsp_d = mk(ST_OK, '0, '0, 1'b1);
          state_d = S_OUT;
        end else begin
          i_d = i_q + 1'b1; idx_d = i_q + 1'b1;
          addr = AW'(i_q + 1'b1);
          state_d = S_WAIT;
        end
      end
      S_OUT: begin
        if (rsp_ready_i) begin
          state_d = cont_q ? S_RD : S_IDLE;
          cont_d  = 1'b0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire
